[hw/rtl/rmq_pkg.sv]
// ----------------------------------------------------------------------------
// rmq_pkg
// shared types and constants for the rotation matrix to quaternion pipeline
// ----------------------------------------------------------------------------
`default_nettype none

package rmq_pkg;

	localparam int FRAC_BITS_DEF = 30;
	localparam int ELEM_W        = 32;
	localparam int DIFF_W        = ELEM_W + 1;
	// quotient bits kept by the divider before saturation
	localparam int Q_BITS        = ELEM_W + 1;
	localparam int N_ELEM        = 10;
	localparam int N_LANE        = 3;

	// index of the component taken from the square root
	typedef enum logic [1:0] {
		SEL_X = 2'd0,
		SEL_Y = 2'd1,
		SEL_Z = 2'd2,
		SEL_W = 2'd3
	} sel_t;

	typedef struct packed {
		sel_t sel;
		logic degen;
	} rmq_ctl_t;

	localparam int CTL_W = $bits(rmq_ctl_t);

endpackage

`default_nettype wire

[hw/rtl/rmq_front.sv]
// ----------------------------------------------------------------------------
// rmq_front
// input register, trace, branch selection, root argument and the three lane sums and differences
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_front
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int ARG_W     = 35
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_vld,
	input  wire logic [N_ELEM*ELEM_W-1:0] in_data,
	output logic                          out_vld,
	output logic [ARG_W-1:0]              out_arg,
	output logic signed [DIFF_W-1:0]      out_diff [N_LANE],
	output rmq_ctl_t                      out_ctl
);

	localparam int AS_W = ARG_W + 1;

	logic                     vld_s1;
	logic signed [ELEM_W-1:0] m_s1 [N_ELEM];

	logic signed [AS_W-1:0]   e    [N_ELEM];
	logic signed [AS_W-1:0]   one, tr, arg;
	logic signed [AS_W-1:0]   arg_c [N_LANE];
	logic signed [DIFF_W-1:0] d    [N_LANE];
	logic signed [DIFF_W-1:0] x    [N_ELEM];
	sel_t                     sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			out_vld <= 1'b0;
		end else if (en) begin
			vld_s1  <= in_vld;
			out_vld <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int n = 0; n < N_ELEM; n++) begin
				m_s1[n] <= in_data[n*ELEM_W +: ELEM_W];
			end
		end
	end

	always_comb begin
		for (int n = 0; n < N_ELEM; n++) begin
			e[n] = AS_W'(m_s1[n]);
			x[n] = DIFF_W'(m_s1[n]);
		end
		one = AS_W'(1) << FRAC_BITS;
		tr  = e[0] + e[4] + e[8] + e[9];
		// all three diagonal arguments in parallel with the trace
		arg_c[0] = e[0] - e[4] - e[8] + one;
		arg_c[1] = e[4] - e[8] - e[0] + one;
		arg_c[2] = e[8] - e[0] - e[4] + one;
		// a tie between the first two diagonals picks Y; a tie with the third keeps the earlier index
		if (m_s1[0] > m_s1[4]) begin
			sel = SEL_X;
		end else begin
			sel = SEL_Y;
		end
		if (m_s1[8] > ((sel == SEL_X) ? m_s1[0] : m_s1[4])) begin
			sel = SEL_Z;
		end
		if (tr >= one) begin
			sel = SEL_W;
		end
		case (sel)
			SEL_X: begin
				arg = arg_c[0];
				d[0] = x[3] + x[1]; d[1] = x[6] + x[2]; d[2] = x[7] - x[5];
			end
			SEL_Y: begin
				arg = arg_c[1];
				d[0] = x[7] + x[5]; d[1] = x[1] + x[3]; d[2] = x[2] - x[6];
			end
			SEL_Z: begin
				arg = arg_c[2];
				d[0] = x[2] + x[6]; d[1] = x[5] + x[7]; d[2] = x[3] - x[1];
			end
			default: begin
				arg = tr;
				d[0] = x[7] - x[5]; d[1] = x[2] - x[6]; d[2] = x[3] - x[1];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ctl.sel   <= sel;
			out_ctl.degen <= (arg <= 0);
			out_arg       <= (arg <= 0) ? '0 : arg[ARG_W-1:0];
			for (int n = 0; n < N_LANE; n++) begin
				out_diff[n] <= d[n];
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/rmq_sqrt.sv]
// ----------------------------------------------------------------------------
// rmq_sqrt
// pipelined integer square root, one result bit per stage
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_sqrt
	import rmq_pkg::*;
#(
	parameter int N_W    = 63,
	parameter int R_W    = 32,
	parameter int SIDE_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              in_vld,
	input  wire logic [N_W-1:0]    in_n,
	input  wire logic [SIDE_W-1:0] in_side,
	output logic                   out_vld,
	output logic [R_W-1:0]         out_root,
	output logic [SIDE_W-1:0]      out_side
);

	logic              vld_s  [R_W+1];
	logic [N_W:0]      rem_s  [R_W+1];
	logic [N_W:0]      r_s    [R_W+1];
	logic [SIDE_W-1:0] side_s [R_W+1];

	assign vld_s[0]  = in_vld;
	assign rem_s[0]  = {1'b0, in_n};
	assign r_s[0]    = '0;
	assign side_s[0] = in_side;

	for (genvar s = 0; s < R_W; s++) begin : g_stage
		localparam int SH = 2 * (R_W - 1 - s);
		logic [N_W:0] bitv, trial;
		logic         ge;

		assign bitv  = (N_W+1)'(1) << SH;
		assign trial = r_s[s] + bitv;
		assign ge    = rem_s[s] >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (en) begin
				vld_s[s+1] <= vld_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[s+1]  <= ge ? (rem_s[s] - trial) : rem_s[s];
				r_s[s+1]    <= ge ? ((r_s[s] >> 1) + bitv) : (r_s[s] >> 1);
				side_s[s+1] <= side_s[s];
			end
		end
	end

	assign out_vld  = vld_s[R_W];
	assign out_root = r_s[R_W][R_W-1:0];
	assign out_side = side_s[R_W];

endmodule

`default_nettype wire

[hw/rtl/rmq_div.sv]
// ----------------------------------------------------------------------------
// rmq_div
// three-lane pipelined restoring divider with signed saturation
// ----------------------------------------------------------------------------
`default_nettype none

module rmq_div
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF,
	parameter int DEN_W     = 34,
	parameter int SIDE_W    = 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   en,
	input  wire logic                   in_vld,
	input  wire logic signed [DIFF_W-1:0] in_diff [N_LANE],
	input  wire logic [DEN_W-1:0]       in_den,
	input  wire logic [SIDE_W-1:0]      in_side,
	output logic                        out_vld,
	output logic [ELEM_W-1:0]           out_q [N_LANE],
	output logic [SIDE_W-1:0]           out_side
);

	localparam int NUM_W = DIFF_W + FRAC_BITS;
	localparam int REM_W = DEN_W + 1;
	localparam logic [Q_BITS-1:0] LIM_POS = Q_BITS'((64'd1 << (ELEM_W-1)) - 64'd1);
	localparam logic [Q_BITS-1:0] LIM_NEG = Q_BITS'(64'd1 << (ELEM_W-1));

	logic              vld_s  [Q_BITS+1];
	logic [DEN_W-1:0]  den_s  [Q_BITS+1];
	logic [SIDE_W-1:0] side_s [Q_BITS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s[0] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			den_s[0]  <= in_den;
			side_s[0] <= in_side;
		end
	end

	for (genvar s = 0; s < Q_BITS; s++) begin : g_ctl
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[s+1] <= 1'b0;
			end else if (en) begin
				vld_s[s+1] <= vld_s[s];
			end
		end
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[s+1]  <= den_s[s];
				side_s[s+1] <= side_s[s];
			end
		end
	end

	for (genvar l = 0; l < N_LANE; l++) begin : g_lane
		logic              neg_s  [Q_BITS+1];
		logic              over_s [Q_BITS+1];
		logic [REM_W-1:0]  rem_s  [Q_BITS+1];
		logic [Q_BITS-1:0] low_s  [Q_BITS+1];
		logic [Q_BITS-1:0] q_s    [Q_BITS+1];

		logic [DIFF_W-1:0] mag;
		logic [NUM_W-1:0]  num;
		logic [REM_W-1:0]  top;
		logic [Q_BITS-1:0] lim, qmag;

		assign mag = in_diff[l][DIFF_W-1] ? (DIFF_W'(0) - DIFF_W'(in_diff[l]))
		                                  : DIFF_W'(in_diff[l]);
		assign num = {mag, {FRAC_BITS{1'b0}}};
		assign top = REM_W'(num[NUM_W-1:Q_BITS]);

		// a quotient too wide for the kept bits is flagged on entry and saturates at the output
		always_ff @(posedge clk) begin
			if (en) begin
				neg_s[0]  <= in_diff[l][DIFF_W-1];
				over_s[0] <= top >= REM_W'(in_den);
				rem_s[0]  <= top;
				low_s[0]  <= num[Q_BITS-1:0];
				q_s[0]    <= '0;
			end
		end

		for (genvar s = 0; s < Q_BITS; s++) begin : g_stage
			logic [REM_W-1:0] rem2;
			logic             ge;

			assign rem2 = {rem_s[s][DEN_W-1:0], low_s[s][Q_BITS-1]};
			assign ge   = rem2 >= REM_W'(den_s[s]);

			always_ff @(posedge clk) begin
				if (en) begin
					neg_s[s+1]  <= neg_s[s];
					over_s[s+1] <= over_s[s];
					rem_s[s+1]  <= ge ? (rem2 - REM_W'(den_s[s])) : rem2;
					low_s[s+1]  <= {low_s[s][Q_BITS-2:0], 1'b0};
					q_s[s+1]    <= {q_s[s][Q_BITS-2:0], ge};
				end
			end
		end

		assign lim  = neg_s[Q_BITS] ? LIM_NEG : LIM_POS;
		assign qmag = (over_s[Q_BITS] || (q_s[Q_BITS] > lim)) ? lim : q_s[Q_BITS];
		assign out_q[l] = neg_s[Q_BITS] ? ELEM_W'(Q_BITS'(0) - qmag) : qmag[ELEM_W-1:0];
	end

	assign out_vld  = vld_s[Q_BITS];
	assign out_side = side_s[Q_BITS];

endmodule

`default_nettype wire

[hw/rtl/rotation_matrix_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_top
// rotation matrix to quaternion, Shepperd's method, fully pipelined
// ----------------------------------------------------------------------------
// channel   dir  handshake          payload
// s_*       in   s_tvalid/s_tready  s_tdata: elem_0_0 .. elem_2_2, elem_3_3
// m_*       out  m_tvalid/m_tready  m_tdata: quat_x..quat_w, m_tuser: degenerate
//
// one item accepted per cycle while the output is not stalled on m_tready; the path runs
// through the front registers, the square root stages (one root bit each), the divider
// stages (one quotient bit each) and the output register
// reset clears all valid bits; payload registers are not reset
// a stall on m_tready freezes the whole pipeline, bubbles included
// ----------------------------------------------------------------------------
`default_nettype none

module rotation_matrix_to_quaternion_top
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// elem_0_0, elem_0_1, elem_0_2, elem_1_0, elem_1_1, elem_1_2,
	// elem_2_0, elem_2_1, elem_2_2, elem_3_3
	input  wire logic [N_ELEM*ELEM_W-1:0] s_tdata,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// quat_x, quat_y, quat_z, quat_w
	output logic [4*ELEM_W-1:0]           m_tdata,
	// degenerate
	output logic [0:0]                    m_tuser
);

	localparam int ARG_W  = ((FRAC_BITS > 33) ? FRAC_BITS : 33) + 2;
	localparam int N_W    = ARG_W + FRAC_BITS - 2;
	localparam int R_W    = (N_W + 1) / 2;
	localparam int DEN_W  = R_W + 2;
	localparam int SIDE_W = ELEM_W + CTL_W;
	localparam logic [ELEM_W-1:0] ROOT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};

	logic                     en;
	logic                     fr_vld, sq_vld, dv_vld;
	logic [ARG_W-1:0]         fr_arg;
	logic signed [DIFF_W-1:0] fr_diff [N_LANE];
	logic signed [DIFF_W-1:0] sq_diff [N_LANE];
	rmq_ctl_t                 fr_ctl, sq_ctl, dv_ctl;
	logic [R_W-1:0]           sq_root;
	logic [ELEM_W-1:0]        root_sat, dv_root;
	logic [ELEM_W-1:0]        dv_q [N_LANE];
	logic [CTL_W+N_LANE*DIFF_W-1:0] sq_side_in, sq_side_out;
	logic [SIDE_W-1:0]        dv_side;
	logic [ELEM_W-1:0]        qx, qy, qz, qw;
	sel_t                     sel_q;

	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	rmq_front #(
		.FRAC_BITS (FRAC_BITS),
		.ARG_W     (ARG_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (s_tvalid),
		.in_data  (s_tdata),
		.out_vld  (fr_vld),
		.out_arg  (fr_arg),
		.out_diff (fr_diff),
		.out_ctl  (fr_ctl)
	);

	assign sq_side_in = {fr_ctl, fr_diff[2], fr_diff[1], fr_diff[0]};

	rmq_sqrt #(
		.N_W    (N_W),
		.R_W    (R_W),
		.SIDE_W (CTL_W + N_LANE*DIFF_W)
	) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (fr_vld),
		.in_n     ({fr_arg, {(FRAC_BITS-2){1'b0}}}),
		.in_side  (sq_side_in),
		.out_vld  (sq_vld),
		.out_root (sq_root),
		.out_side (sq_side_out)
	);

	always_comb begin
		for (int n = 0; n < N_LANE; n++) begin
			sq_diff[n] = sq_side_out[n*DIFF_W +: DIFF_W];
		end
		sq_ctl = sq_side_out[N_LANE*DIFF_W +: CTL_W];
		if (R_W > ELEM_W - 1 && (sq_root >> (ELEM_W-1)) != '0) begin
			root_sat = ROOT_MAX;
		end else begin
			root_sat = ELEM_W'(sq_root);
		end
	end

	rmq_div #(
		.FRAC_BITS (FRAC_BITS),
		.DEN_W     (DEN_W),
		.SIDE_W    (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_vld   (sq_vld),
		.in_diff  (sq_diff),
		.in_den   ({sq_root, 2'b00}),
		.in_side  ({sq_ctl, root_sat}),
		.out_vld  (dv_vld),
		.out_q    (dv_q),
		.out_side (dv_side)
	);

	assign dv_root = dv_side[ELEM_W-1:0];
	assign dv_ctl  = dv_side[ELEM_W +: CTL_W];

	always_comb begin
		case (dv_ctl.sel)
			SEL_X: begin
				qx = dv_root; qy = dv_q[0]; qz = dv_q[1]; qw = dv_q[2];
			end
			SEL_Y: begin
				qx = dv_q[1]; qy = dv_root; qz = dv_q[0]; qw = dv_q[2];
			end
			SEL_Z: begin
				qx = dv_q[0]; qy = dv_q[1]; qz = dv_root; qw = dv_q[2];
			end
			default: begin
				qx = dv_q[0]; qy = dv_q[1]; qz = dv_q[2]; qw = dv_root;
			end
		endcase
		if (dv_ctl.degen) begin
			qx = '0; qy = '0; qz = '0; qw = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (en) begin
			m_tvalid <= dv_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata <= {qw, qz, qy, qx};
			m_tuser <= dv_ctl.degen;
			sel_q   <= dv_ctl.sel;
		end
	end

	// degenerate results carry zero components
	a_degen_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata == '0)
		else $error("degenerate item with nonzero components");

	// the square-root component of a regular result is strictly positive
	a_root_pos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[0] |->
		!m_tdata[sel_q*ELEM_W + ELEM_W-1] && m_tdata[sel_q*ELEM_W +: ELEM_W] != '0)
		else $error("root component not positive");

	// the input side only stalls while a result waits downstream
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready)
		else $error("input stalled without output backpressure");

endmodule

`default_nettype wire

[tb/rmq_checker.sv]
// ----------------------------------------------------------------------------
// rmq_checker
// watches both channels, predicts each quaternion and compares field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rmq_checker
	import rmq_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     s_tvalid,
	input  wire logic                     s_tready,
	input  wire logic [N_ELEM*ELEM_W-1:0] s_tdata,
	input  wire logic                     m_tvalid,
	input  wire logic                     m_tready,
	input  wire logic [4*ELEM_W-1:0]      m_tdata,
	input  wire logic [0:0]               m_tuser,
	output int                            fail_count,
	output int                            pending,
	output int                            quats_seen,
	output int                            degen_seen
);

	typedef struct packed {
		logic [31:0] w;
		logic [31:0] z;
		logic [31:0] y;
		logic [31:0] x;
	} quat_t;

	typedef struct {
		quat_t q;
		logic  degen;
	} quat_res_t;

	quat_res_t quat_queue[$];

	// signed 33-bit numerator scaled by the fraction bits over 4*root, saturated
	function automatic logic [31:0] scaled_ratio(longint d, longint unsigned den);
		logic [127:0] num;
		logic [127:0] quo;
		logic         neg;
		longint unsigned mag;
		begin
			neg = d < 0;
			mag = neg ? longint'(-d) : longint'(d);
			num = 128'(mag) << FRAC_BITS;
			quo = num / 128'(den);
			if (neg) begin
				if (quo > 128'h8000_0000) quo = 128'h8000_0000;
				scaled_ratio = 32'(-quo);
			end else begin
				if (quo > 128'h7FFF_FFFF) quo = 128'h7FFF_FFFF;
				scaled_ratio = quo[31:0];
			end
		end
	endfunction

	function automatic longint unsigned isqrt128(logic [127:0] n);
		longint unsigned r;
		longint unsigned t;
		begin
			r = 0;
			for (int b = 63; b >= 0; b--) begin
				t = r | (64'd1 << b);
				if ((128'(t) * 128'(t)) <= n) r = t;
			end
			isqrt128 = r;
		end
	endfunction

	function automatic quat_res_t predict_quat(logic [N_ELEM*ELEM_W-1:0] d);
		longint m[3][3];
		longint one;
		longint tr;
		longint arg;
		longint unsigned root;
		longint unsigned den;
		logic [31:0] c[4];
		int i, j, k;
		quat_res_t res;
		begin
			for (int r = 0; r < 3; r++)
				for (int cc = 0; cc < 3; cc++)
					m[r][cc] = longint'($signed(d[(r*3+cc)*32 +: 32]));
			one = longint'(1) << FRAC_BITS;
			tr = m[0][0] + m[1][1] + m[2][2] + longint'($signed(d[9*32 +: 32]));
			j = 0;
			k = 0;
			if (tr >= one) begin
				i = SEL_W;
				arg = tr;
			end else begin
				i = (m[0][0] > m[1][1]) ? 0 : 1;
				if (m[2][2] > m[i][i]) i = 2;
				j = (i + 1) % 3;
				k = (j + 1) % 3;
				arg = m[i][i] - m[j][j] - m[k][k] + one;
			end
			res.degen = 1'b0;
			res.q = '0;
			if (arg <= 0) begin
				res.degen = 1'b1;
			end else begin
				root = isqrt128(128'(arg) << (FRAC_BITS - 2));
				den = root << 2;
				if (i == SEL_W) begin
					c[3] = (root > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : root[31:0];
					c[0] = scaled_ratio(m[2][1] - m[1][2], den);
					c[1] = scaled_ratio(m[0][2] - m[2][0], den);
					c[2] = scaled_ratio(m[1][0] - m[0][1], den);
				end else begin
					c[i] = (root > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : root[31:0];
					c[j] = scaled_ratio(m[j][i] + m[i][j], den);
					c[k] = scaled_ratio(m[k][i] + m[i][k], den);
					c[3] = scaled_ratio(m[k][j] - m[j][k], den);
				end
				res.q = {c[3], c[2], c[1], c[0]};
			end
			predict_quat = res;
		end
	endfunction

	assign pending = quat_queue.size();

	always @(posedge clk or negedge arst_n) begin
		quat_res_t exp_r;
		quat_t act;
		if (!arst_n) begin
			fail_count <= 0;
			quats_seen <= 0;
			degen_seen <= 0;
		end else begin
			if (s_tvalid && s_tready) quat_queue.push_back(predict_quat(s_tdata));
			if (m_tvalid && m_tready) begin
				act = m_tdata;
				quats_seen <= quats_seen + 1;
				if (m_tuser[0]) degen_seen <= degen_seen + 1;
				if (quat_queue.size() == 0) begin
					if (fail_count < 10) $display("unexpected quaternion %h", m_tdata);
					fail_count <= fail_count + 1;
				end else begin
					exp_r = quat_queue.pop_front();
					if (act.x !== exp_r.q.x || act.y !== exp_r.q.y || act.z !== exp_r.q.z ||
							act.w !== exp_r.q.w || m_tuser[0] !== exp_r.degen) begin
						if (fail_count < 10)
							$display("mismatch: exp x %h y %h z %h w %h dg %b, got x %h y %h z %h w %h dg %b",
								exp_r.q.x, exp_r.q.y, exp_r.q.z, exp_r.q.w, exp_r.degen,
								act.x, act.y, act.z, act.w, m_tuser[0]);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end

endmodule

[tb/tb_rotation_matrix_to_quaternion_top.sv]
// ----------------------------------------------------------------------------
// tb_rotation_matrix_to_quaternion_top
// directed corner matrices then random bounded matrices and noise, with random stalls
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion_top;
	import rmq_pkg::*;

	localparam int LATENCY   = 69;
	localparam int IDLE_LIMIT = 20000;
	localparam int ONE_Q     = 1 << FRAC_BITS_DEF;

	logic                     clk;
	logic                     arst_n;
	logic                     s_tvalid;
	logic                     s_tready;
	logic [N_ELEM*ELEM_W-1:0] s_tdata;
	logic                     m_tvalid;
	logic                     m_tready;
	logic [4*ELEM_W-1:0]      m_tdata;
	logic [0:0]               m_tuser;
	int fail_count, pending, quats_seen, degen_seen;
	int idle_cycles;
	bit quiet_phase;
	bit hold_sink;
	bit stim_done;

	rotation_matrix_to_quaternion_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	rmq_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.fail_count(fail_count), .pending(pending),
		.quats_seen(quats_seen), .degen_seen(degen_seen)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic [31:0] rand_elem();
		case ($urandom_range(0, 5))
			0: rand_elem = 32'h8000_0000;
			1: rand_elem = 32'h7FFF_FFFF;
			2: rand_elem = $urandom_range(0, 2) == 0 ? 32'd0 : ONE_Q;
			default: rand_elem = $urandom;
		endcase
	endfunction

	// random matrix: signed values of modest size, with the corner at one in most draws
	function automatic logic [N_ELEM*ELEM_W-1:0] rand_matrix();
		logic [N_ELEM*ELEM_W-1:0] d;
		begin
			for (int e = 0; e < 9; e++)
				d[e*32 +: 32] = 32'($signed($urandom_range(0, 2*ONE_Q)) - ONE_Q);
			d[9*32 +: 32] = ($urandom_range(0, 9) == 0) ? $urandom : ONE_Q;
			rand_matrix = d;
		end
	endfunction

	task automatic send_item(input logic [N_ELEM*ELEM_W-1:0] d);
		while (!quiet_phase && $urandom_range(0, 99) < 25) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	function automatic logic [N_ELEM*ELEM_W-1:0] diag(int a, int b, int c, int cn);
		logic [N_ELEM*ELEM_W-1:0] d;
		begin
			d = '0;
			d[0*32 +: 32] = a;
			d[4*32 +: 32] = b;
			d[8*32 +: 32] = c;
			d[9*32 +: 32] = cn;
			diag = d;
		end
	endfunction

	// sink side: random stalls, plus a long hold-off on request
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) m_tready <= 1'b0;
		else m_tready <= !hold_sink && (quiet_phase || $urandom_range(0, 99) >= 25);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		logic [N_ELEM*ELEM_W-1:0] d;
		int t;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet_phase = 1'b0;
		hold_sink = 1'b0;
		stim_done = 1'b0;
		idle_cycles = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: identity, each diagonal branch, ties, extremes
		send_item(diag(ONE_Q, ONE_Q, ONE_Q, ONE_Q));
		send_item(diag(ONE_Q, -ONE_Q, -ONE_Q, ONE_Q));
		send_item(diag(-ONE_Q, ONE_Q, -ONE_Q, ONE_Q));
		send_item(diag(-ONE_Q, -ONE_Q, ONE_Q, ONE_Q));
		send_item(diag(0, 0, 0, 0));
		send_item(diag(-ONE_Q, -ONE_Q, -ONE_Q, 0));
		send_item(diag(-ONE_Q, -ONE_Q, -ONE_Q, -ONE_Q));
		send_item(diag(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		send_item(diag(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		send_item(diag(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 0));
		send_item({N_ELEM{32'h7FFF_FFFF}});
		send_item({N_ELEM{32'h8000_0000}});
		send_item({N_ELEM{32'hFFFF_FFFF}});
		send_item('0);
		d = diag(1, 0, 0, 0);
		d[1*32 +: 32] = 32'h8000_0000;
		d[3*32 +: 32] = 32'h7FFF_FFFF;
		send_item(d);
		d = diag(ONE_Q - 1, 0, 0, 0);
		d[5*32 +: 32] = 32'h8000_0000;
		d[7*32 +: 32] = 32'h7FFF_FFFF;
		send_item(d);
		send_item(diag(ONE_Q, 0, 0, 0));

		for (int n = 0; n < 1300; n++) begin
			if (n == 300) begin
				// receiver holds off while items keep coming
				hold_sink = 1'b1;
				fork
					begin
						repeat (400) @(posedge clk);
						hold_sink = 1'b0;
					end
				join_none
			end
			if (n == 600) begin
				s_tvalid <= 1'b0;
				while (pending != 0) @(posedge clk);
			end
			quiet_phase = (n >= 800 && n < 1000);
			t = $urandom_range(0, 9);
			if (t < 7) d = rand_matrix();
			else for (int e = 0; e < N_ELEM; e++) d[e*32 +: 32] = rand_elem();
			send_item(d);
		end
		s_tvalid <= 1'b0;
		quiet_phase = 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
		$display("covered %0d quaternions, %0d degenerate, with stalls on both sides",
			quats_seen, degen_seen);
		if (fail_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

[filelist.f]
hw/rtl/rmq_pkg.sv
hw/rtl/rmq_front.sv
hw/rtl/rmq_sqrt.sv
hw/rtl/rmq_div.sv
hw/rtl/rotation_matrix_to_quaternion_top.sv
tb/rmq_checker.sv
tb/tb_rotation_matrix_to_quaternion_top.sv
